>>> rtl/core/bole_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bole_pkg
// Shared constants and codes for the ordered list engine.
// ----------------------------------------------------------------------------
package bole_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = 4;
    localparam int CNT_W    = 5;
    localparam int POS_W    = 8;
    localparam int DATA_W   = 32;

    typedef enum logic [2:0] {
        CMD_INS_FRONT = 3'd0,
        CMD_INS_END   = 3'd1,
        CMD_INS_POS   = 3'd2,
        CMD_DEL_FRONT = 3'd3,
        CMD_DEL_END   = 3'd4,
        CMD_DEL_POS   = 3'd5,
        CMD_SEARCH    = 3'd6
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_FULL     = 3'd2,
        ST_BADPOS   = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

endpackage

`default_nettype wire

>>> rtl/core/bole_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bole_ram
// Generic simple dual-port RAM, one write port, registered read.
// ----------------------------------------------------------------------------
module bole_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

>>> rtl/core/bounded_ordered_list_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_ordered_list_engine
// Ordered list of up to CAPACITY signed values kept in one RAM.
// ----------------------------------------------------------------------------
// One command at a time. Appends, deletes of the last element, rejected and
// unused commands show their result in the cycle after they are accepted.
// An insert elsewhere moves every element from the position to the end
// up by one entry, one RAM read and write per cycle, then writes the new
// value. A delete elsewhere moves every element behind the position down
// by one entry. A search reads one entry per cycle until the first match
// or the last entry. The single RAM port pair sets this pace. A result
// stays until it is read, and the next command is taken from the cycle
// after that.
module bounded_ordered_list_engine
    import bole_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [2:0]         cmd,
    input  wire logic [POS_W-1:0]   position,
    input  wire logic signed [31:0] value,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [2:0]              status,
    output logic [CNT_W-1:0]        found_position,
    output logic [CNT_W-1:0]        length
);

    typedef enum logic [2:0] {S_IDLE, S_UP, S_PUT, S_DOWN, S_SEARCH} state_t;

    state_t              state_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [IDX_W-1:0]    ptr_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [DATA_W-1:0]   val_reg;
    logic                out_valid_reg;
    status_t             status_reg;
    logic [CNT_W-1:0]    found_reg;

    logic                accept;
    logic                we;
    logic [IDX_W-1:0]    wr_addr;
    logic [DATA_W-1:0]   wr_data;
    logic [IDX_W-1:0]    rd_addr;
    logic [DATA_W-1:0]   rd_data;

    logic                full;
    logic                empty;
    logic [POS_W-1:0]    pos_m1;
    logic                ins_pos_ok;
    logic                del_pos_ok;
    logic [CNT_W-1:0]    ins_idx;
    logic [CNT_W-1:0]    del_idx;
    logic [CNT_W-1:0]    last;
    logic                ptr_last;

    assign in_ready       = (state_reg == S_IDLE) && !out_valid_reg;
    assign accept         = in_valid && in_ready;
    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign found_position = found_reg;
    assign length         = count_reg;

    assign full       = (count_reg == CNT_W'(CAPACITY));
    assign empty      = (count_reg == '0);
    assign pos_m1     = position - POS_W'(1);
    assign ins_pos_ok = (position != '0) && (pos_m1 <= POS_W'(count_reg));
    assign del_pos_ok = (position != '0) && (position <= POS_W'(count_reg));
    assign last       = count_reg - CNT_W'(1);
    assign ptr_last   = (CNT_W'(ptr_reg) == last);

    always_comb
    begin
        case (cmd)
            CMD_INS_FRONT: ins_idx = '0;
            CMD_INS_END:   ins_idx = count_reg;
            default:       ins_idx = pos_m1[CNT_W-1:0];
        endcase
        case (cmd)
            CMD_DEL_FRONT: del_idx = '0;
            CMD_DEL_END:   del_idx = last;
            default:       del_idx = pos_m1[CNT_W-1:0];
        endcase
    end

    always_comb
    begin
        we      = 1'b0;
        wr_addr = ptr_reg;
        wr_data = rd_data;
        rd_addr = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (cmd inside {CMD_INS_FRONT, CMD_INS_END, CMD_INS_POS})
                    begin
                        if (ins_idx == count_reg)
                        begin
                            we      = !full && (cmd != CMD_INS_POS || ins_pos_ok);
                            wr_addr = ins_idx[IDX_W-1:0];
                            wr_data = value;
                        end
                        rd_addr = last[IDX_W-1:0];
                    end
                    else if (cmd inside {CMD_DEL_FRONT, CMD_DEL_END, CMD_DEL_POS})
                    begin
                        rd_addr = del_idx[IDX_W-1:0] + IDX_W'(1);
                    end
                end
            end
            S_UP:
            begin
                we      = 1'b1;
                wr_addr = ptr_reg + IDX_W'(1);
                rd_addr = ptr_reg - IDX_W'(1);
            end
            S_PUT:
            begin
                we      = 1'b1;
                wr_addr = idx_reg;
                wr_data = val_reg;
            end
            S_DOWN:
            begin
                we      = 1'b1;
                wr_addr = ptr_reg - IDX_W'(1);
                rd_addr = ptr_reg + IDX_W'(1);
            end
            S_SEARCH:
            begin
                rd_addr = ptr_reg + IDX_W'(1);
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    bole_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk     (clk),
        .we      (we),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            ptr_reg       <= '0;
            idx_reg       <= '0;
            val_reg       <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= ST_OK;
            found_reg     <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        found_reg <= '0;
                        status_reg <= ST_OK;
                        out_valid_reg <= 1'b1;
                        val_reg <= value;
                        if (cmd inside {CMD_INS_FRONT, CMD_INS_END, CMD_INS_POS})
                        begin
                            if (full)
                            begin
                                status_reg <= ST_FULL;
                            end
                            else if (cmd == CMD_INS_POS && !ins_pos_ok)
                            begin
                                status_reg <= ST_BADPOS;
                            end
                            else if (ins_idx == count_reg)
                            begin
                                count_reg <= count_reg + CNT_W'(1);
                            end
                            else
                            begin
                                out_valid_reg <= 1'b0;
                                ptr_reg   <= last[IDX_W-1:0];
                                idx_reg   <= ins_idx[IDX_W-1:0];
                                state_reg <= S_UP;
                            end
                        end
                        else if (cmd inside {CMD_DEL_FRONT, CMD_DEL_END, CMD_DEL_POS})
                        begin
                            if (empty)
                            begin
                                status_reg <= ST_EMPTY;
                            end
                            else if (cmd == CMD_DEL_POS && !del_pos_ok)
                            begin
                                status_reg <= ST_BADPOS;
                            end
                            else if (del_idx == last)
                            begin
                                count_reg <= last;
                            end
                            else
                            begin
                                out_valid_reg <= 1'b0;
                                ptr_reg   <= del_idx[IDX_W-1:0] + IDX_W'(1);
                                state_reg <= S_DOWN;
                            end
                        end
                        else if (cmd == CMD_SEARCH)
                        begin
                            if (empty)
                            begin
                                status_reg <= ST_EMPTY;
                            end
                            else
                            begin
                                out_valid_reg <= 1'b0;
                                ptr_reg   <= '0;
                                state_reg <= S_SEARCH;
                            end
                        end
                    end
                end
                S_UP:
                begin
                    if (ptr_reg == idx_reg)
                    begin
                        state_reg <= S_PUT;
                    end
                    else
                    begin
                        ptr_reg <= ptr_reg - IDX_W'(1);
                    end
                end
                S_PUT:
                begin
                    count_reg     <= count_reg + CNT_W'(1);
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                S_DOWN:
                begin
                    if (ptr_last)
                    begin
                        count_reg     <= last;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                    else
                    begin
                        ptr_reg <= ptr_reg + IDX_W'(1);
                    end
                end
                S_SEARCH:
                begin
                    if (rd_data == val_reg)
                    begin
                        found_reg     <= CNT_W'(ptr_reg) + CNT_W'(1);
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                    else if (ptr_last)
                    begin
                        status_reg    <= ST_NOTFOUND;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                    else
                    begin
                        ptr_reg <= ptr_reg + IDX_W'(1);
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("element count above capacity");
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && found_reg != '0 |-> status_reg == ST_OK)
        else $error("match position without ok status");
    a_busy_no_out: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !out_valid_reg)
        else $error("result shown while command in progress");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |-> $rose(out_valid_reg))
        else $error("count changed without a result");
`endif

endmodule

`default_nettype wire
